// ----- rtl/npcs_pkg.sv -----
// ----------------------------------------------------------------------------
// npcs_pkg: shared constants for the nearest palette color search
// Palette geometry, stream widths and command codes.
// ----------------------------------------------------------------------------
package npcs_pkg;

  // palette geometry
  localparam int unsigned PaletteDepth = 256;
  localparam int unsigned IdxW         = $clog2(PaletteDepth);
  localparam int unsigned CntW         = $clog2(PaletteDepth + 1);

  // configuration register
  localparam int unsigned SizeW        = 9;
  localparam logic [SizeW-1:0] SizeReset = SizeW'(256);

  // stream widths
  localparam int unsigned InDataW  = 80;
  localparam int unsigned OutDataW = 8;

  // color and distance
  localparam int unsigned ChanW  = 8;
  localparam int unsigned EntryW = 3 * ChanW;
  localparam int unsigned SqW    = 2 * ChanW;
  localparam int unsigned DistW  = SqW + 2;
  localparam logic [DistW-1:0] DistLimit = DistW'(65536);

  // command codes carried in tuser
  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_QUERY = 1'b1
  } cmd_e;

endpackage

// ----- rtl/nearest_palette_color_search_top.sv -----
// ----------------------------------------------------------------------------
// nearest_palette_color_search_top: palette store with nearest-color query
// Stores 24-bit palette entries in a synchronous RAM and answers queries with
// the index of the first entry at the smallest squared distance below 65536, else 0.
// ----------------------------------------------------------------------------
//
//  channel  | direction | transaction carries
//  ---------+-----------+-------------------------------------------------
//  s_axis   | in        | write entry (tuser=0) or query (tuser=1)
//  m_axis   | out       | nearest_index, one per query, none per write
//  cfg      | in        | palette_size, taken on any cycle cfg_we_i is high
//
//  A write leaves the block idle; tready stays high after it.
//  A query holds s_axis_tready low while min(palette_size, 256) entries are
//  scanned and until the result enters the output register: the single RAM
//  read port delivers one entry per cycle into a two-stage square /
//  sum-and-compare pipeline, which then drains.
//  Reset is asynchronous, active low; the palette RAM is not cleared.
//  A finished result waits in the output register; a new query may start
//  while it waits, and only a second finished result stalls on it.
//
module nearest_palette_color_search_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration
  input  logic                          cfg_we_i,
  input  logic [npcs_pkg::SizeW-1:0]    cfg_wdata_i,     // palette_size
  // input stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // [7:0] entry_index, [23:8] entry_red, [39:24] entry_green,
  // [55:40] entry_blue, [63:56] target_red, [71:64] target_green,
  // [79:72] target_blue
  input  logic [npcs_pkg::InDataW-1:0]  s_axis_tdata,
  input  logic                          s_axis_tuser,    // [0] command
  // output stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [npcs_pkg::OutDataW-1:0] m_axis_tdata     // [7:0] nearest_index
);
  import npcs_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_HOLD = 3'b100
  } state_e;

  // --- input field unpacking ------------------------------------------------
  logic [7:0]       in_index;
  logic [ChanW-1:0] in_red, in_green, in_blue;   // top byte of each 16-bit channel
  logic [ChanW-1:0] in_tr, in_tg, in_tb;

  assign in_index = s_axis_tdata[7:0];
  assign in_red   = s_axis_tdata[23:16];
  assign in_green = s_axis_tdata[39:32];
  assign in_blue  = s_axis_tdata[55:48];
  assign in_tr    = s_axis_tdata[63:56];
  assign in_tg    = s_axis_tdata[71:64];
  assign in_tb    = s_axis_tdata[79:72];

  // --- registers --------------------------------------------------------------
  state_e            state_q, state_d;
  logic [SizeW-1:0]  cfg_size_q;
  logic [CntW-1:0]   issue_cnt_q, issue_cnt_d;
  logic [CntW-1:0]   count_q, count_d;
  logic [ChanW-1:0]  tr_q, tg_q, tb_q;
  logic              v1_q, v2_q;                 // read data / squares valid
  logic [IdxW-1:0]   idx1_q, idx2_q;
  logic [EntryW-1:0] rdata_q;
  logic [SqW-1:0]    sq_r_q, sq_g_q, sq_b_q;
  logic [DistW-1:0]  best_q, best_d;
  logic [IdxW-1:0]   win_q, win_d;
  logic              m_valid_q, m_valid_d;
  logic [7:0]        m_data_q, m_data_d;

  logic [EntryW-1:0] palette_mem [PaletteDepth];

  // --- handshakes -------------------------------------------------------------
  logic in_acc, wr_acc, qry_acc, out_free;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign wr_acc   = in_acc && (s_axis_tuser == CMD_WRITE);
  assign qry_acc  = in_acc && (s_axis_tuser == CMD_QUERY);
  assign out_free = !m_valid_q || m_axis_tready;

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  // --- palette RAM: writes only while idle, reads only while scanning -------
  logic            mem_we, mem_re;
  logic [IdxW-1:0] mem_waddr, mem_raddr;

  assign mem_we    = wr_acc && (32'(in_index) < PaletteDepth);
  assign mem_waddr = IdxW'(in_index);
  assign mem_re    = (state_q == ST_SCAN) && (issue_cnt_q < count_q);
  assign mem_raddr = issue_cnt_q[IdxW-1:0];

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      palette_mem[mem_waddr] <= {in_red, in_green, in_blue};
    end
    if (mem_re) begin
      rdata_q <= palette_mem[mem_raddr];
    end
  end

  // --- stage 2: per-channel squared differences --------------------------------
  logic [ChanW-1:0] e_r, e_g, e_b, d_r, d_g, d_b;

  always_comb begin
    e_r = rdata_q[23:16];
    e_g = rdata_q[15:8];
    e_b = rdata_q[7:0];
    d_r = (e_r > tr_q) ? (e_r - tr_q) : (tr_q - e_r);
    d_g = (e_g > tg_q) ? (e_g - tg_q) : (tg_q - e_g);
    d_b = (e_b > tb_q) ? (e_b - tb_q) : (tb_q - e_b);
  end

  always_ff @(posedge clk_i) begin
    sq_r_q <= d_r * d_r;
    sq_g_q <= d_g * d_g;
    sq_b_q <= d_b * d_b;
    idx2_q <= idx1_q;
    if (mem_re) begin
      idx1_q <= mem_raddr;
    end
  end

  // --- stage 3: sum and compare, strict less keeps the first minimum --------
  logic [DistW-1:0] sum_dist;
  logic             scan_done;

  assign sum_dist  = DistW'(sq_r_q) + DistW'(sq_g_q) + DistW'(sq_b_q);
  assign scan_done = (issue_cnt_q == count_q) && !v1_q && !v2_q;

  // --- control ------------------------------------------------------------------
  always_comb begin
    state_d     = state_q;
    issue_cnt_d = issue_cnt_q;
    count_d     = count_q;
    best_d      = best_q;
    win_d       = win_q;
    m_valid_d   = m_valid_q && !m_axis_tready;
    m_data_d    = m_data_q;

    case (state_q)
      ST_IDLE: begin
        if (qry_acc) begin
          state_d     = ST_SCAN;
          issue_cnt_d = '0;
          count_d     = (32'(cfg_size_q) > PaletteDepth) ? CntW'(PaletteDepth)
                                                         : CntW'(cfg_size_q);
          best_d      = DistLimit;
          win_d       = '0;
        end
      end
      ST_SCAN: begin
        if (mem_re) begin
          issue_cnt_d = issue_cnt_q + 1'b1;
        end
        if (v2_q && (sum_dist < best_q)) begin
          best_d = sum_dist;
          win_d  = idx2_q;
        end
        if (scan_done) begin
          if (out_free) begin
            state_d   = ST_IDLE;
            m_valid_d = 1'b1;
            m_data_d  = 8'(win_q);
          end else begin
            state_d = ST_HOLD;
          end
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          state_d   = ST_IDLE;
          m_valid_d = 1'b1;
          m_data_d  = 8'(win_q);
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cfg_size_q  <= SizeReset;
      issue_cnt_q <= '0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      m_valid_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      issue_cnt_q <= issue_cnt_d;
      v1_q        <= mem_re;
      v2_q        <= v1_q;
      m_valid_q   <= m_valid_d;
      if (cfg_we_i) begin
        cfg_size_q <= cfg_wdata_i;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    count_q  <= count_d;
    best_q   <= best_d;
    win_q    <= win_d;
    m_data_q <= m_data_d;
    if (qry_acc) begin
      tr_q <= in_tr;
      tg_q <= in_tg;
      tb_q <= in_tb;
    end
  end

endmodule

// ----- rtl/npcs_checker.sv -----
// ----------------------------------------------------------------------------
// npcs_checker: port-level checks for the nearest palette color search
// Bound to the top level; watches stream transactions over time.
// ----------------------------------------------------------------------------
module npcs_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          cfg_we_i,
  input logic [npcs_pkg::SizeW-1:0]    cfg_wdata_i,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic [npcs_pkg::InDataW-1:0]  s_axis_tdata,
  input logic                          s_axis_tuser,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [npcs_pkg::OutDataW-1:0] m_axis_tdata
);
  import npcs_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // the input stays ready after a write transaction
  a_write_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser == CMD_WRITE) |=> s_axis_tready)
    else $error("input not ready after write");

  // a query blocks the input while it scans
  a_query_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser == CMD_QUERY) |=> !s_axis_tready)
    else $error("input ready right after query");

  // a new result appears only at the end of a scan
  a_result_from_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("result without a scan");

  // unused here, kept visible to the bind
  logic unused_cfg;
  assign unused_cfg = cfg_we_i ^ (^cfg_wdata_i) ^ (^s_axis_tdata);

endmodule

bind nearest_palette_color_search_top npcs_checker u_npcs_checker (.*);

// ----- tb/nearest_palette_color_search_checker.sv -----
// ----------------------------------------------------------------------------
// nearest_palette_color_search_checker: scoreboard for the palette search
// Watches the cfg, s_axis and m_axis channels, keeps its own palette copy,
// predicts the nearest index for each query and compares every result.
// ----------------------------------------------------------------------------
module nearest_palette_color_search_checker
  import npcs_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [SizeW-1:0]     cfg_wdata_i,
  input  logic                 s_axis_tvalid,
  input  logic                 s_axis_tready,
  input  logic [InDataW-1:0]   s_axis_tdata,
  input  logic                 s_axis_tuser,
  input  logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  input  logic [OutDataW-1:0]  m_axis_tdata,
  output int                   fail_count_o,
  output int                   pending_o,
  output int                   checked_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // s_axis tdata layout, lowest field last
  typedef struct packed {
    logic [7:0]  target_blue;
    logic [7:0]  target_green;
    logic [7:0]  target_red;
    logic [15:0] entry_blue;
    logic [15:0] entry_green;
    logic [15:0] entry_red;
    logic [7:0]  entry_index;
  } stream_item_t;

  logic [EntryW-1:0]   palette_copy [PaletteDepth];
  logic [SizeW-1:0]    palette_size;
  logic [OutDataW-1:0] nearest_index_q [$];

  initial begin
    fail_count_o = 0;
    checked_o    = 0;
    pending_o    = 0;
  end

  function automatic int unsigned chan_gap_sq(input logic [7:0] a, input logic [7:0] b);
    int unsigned d;
    d = (a > b) ? a - b : b - a;
    return d * d;
  endfunction

  // first entry at the smallest distance below the limit, else index 0
  function automatic logic [OutDataW-1:0] nearest_entry(input logic [7:0] tr,
                                                        input logic [7:0] tg,
                                                        input logic [7:0] tb);
    int unsigned span, best, total, winner, i;
    logic [EntryW-1:0] e;
    span   = (palette_size > PaletteDepth) ? PaletteDepth : palette_size;
    best   = DistLimit;
    winner = 0;
    for (i = 0; i < span; i++) begin
      e     = palette_copy[i];
      total = chan_gap_sq(e[23:16], tr) + chan_gap_sq(e[15:8], tg) + chan_gap_sq(e[7:0], tb);
      if (total < best) begin
        best   = total;
        winner = i;
      end
    end
    return winner[OutDataW-1:0];
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    stream_item_t        item;
    logic [OutDataW-1:0] want;
    if (!rst_ni) begin
      palette_size <= SizeReset;
      nearest_index_q.delete();
      pending_o    <= 0;
    end else begin
      if (cfg_we_i) palette_size <= cfg_wdata_i;
      if (s_axis_tvalid && s_axis_tready) begin
        item = s_axis_tdata;
        if (s_axis_tuser == CMD_WRITE) begin
          palette_copy[item.entry_index] <= {item.entry_red[15:8], item.entry_green[15:8],
                                             item.entry_blue[15:8]};
        end else begin
          nearest_index_q.push_back(nearest_entry(item.target_red, item.target_green,
                                                  item.target_blue));
        end
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (nearest_index_q.size() == 0) begin
          $error("nearest_index: no result expected, got %0d", m_axis_tdata);
          fail_count_o++;
        end else begin
          want = nearest_index_q.pop_front();
          checked_o++;
          if (m_axis_tdata !== want) begin
            $error("nearest_index: expected %0d, got %0d", want, m_axis_tdata);
            fail_count_o++;
          end
        end
      end
      pending_o <= nearest_index_q.size();
    end
  end

endmodule

// ----- tb/tb_nearest_palette_color_search_top.sv -----
// ----------------------------------------------------------------------------
// tb_nearest_palette_color_search_top: stimulus and verdict for the search
// Directed corner cases, a full palette fill, then random write/query phases
// over several palette sizes with random idling on both streams.
// ----------------------------------------------------------------------------
module tb_nearest_palette_color_search_top;
  import npcs_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // upper bound for the watchdog, far above the slowest run
  localparam int unsigned CycleLimit = 1_000_000;
  localparam int unsigned HoldCycles = 1500;
  localparam int unsigned PhaseItems = 22;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                cfg_we_i      = 1'b0;
  logic [SizeW-1:0]    cfg_wdata_i   = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata  = '0;
  logic                s_axis_tuser  = CMD_WRITE;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;

  int fail_count, pending, checked;

  // stimulus knobs, changed only by nonblocking assignment
  bit tx_calm     = 1'b0;
  bit rx_calm     = 1'b0;
  bit rx_hold_go  = 1'b0;
  bit hold_spent  = 1'b0;
  int unsigned hold_left = 0;

  // top bytes of what each palette entry holds, used to aim queries
  logic [EntryW-1:0] shade [PaletteDepth];
  int unsigned writes_sent  = 0;
  int unsigned queries_sent = 0;
  int unsigned cycle_count  = 0;

  nearest_palette_color_search_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  nearest_palette_color_search_checker scoreboard (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .fail_count_o  (fail_count),
    .pending_o     (pending),
    .checked_o     (checked)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
      $display("tb_nearest_palette_color_search_top NOT OK");
      $finish;
    end
  end

  // receiver: random backpressure, one long hold-off on request, calm stretch
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      m_axis_tready <= 1'b0;
      hold_left     <= hold_left - 1;
    end else if (rx_hold_go && !hold_spent) begin
      m_axis_tready <= 1'b0;
      hold_left     <= HoldCycles;
      hold_spent    <= 1'b1;
    end else begin
      m_axis_tready <= rx_calm || ($urandom_range(99) >= 30);
    end
  end

  // offer one transaction; tvalid is left high so back-to-back items
  // need no second assignment in the same step
  task automatic push_item(input cmd_e cmd, input logic [InDataW-1:0] data);
    if (!tx_calm) begin
      while ($urandom_range(99) < 30) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk_i);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= data;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic send_write(input logic [7:0] idx, input logic [15:0] r,
                            input logic [15:0] g, input logic [15:0] b);
    shade[idx] = {r[15:8], g[15:8], b[15:8]};
    writes_sent++;
    push_item(CMD_WRITE, {8'($urandom), 8'($urandom), 8'($urandom), b, g, r, idx});
  endtask

  task automatic send_query(input logic [7:0] tr, input logic [7:0] tg, input logic [7:0] tb);
    queries_sent++;
    push_item(CMD_QUERY, {tb, tg, tr, 16'($urandom), 16'($urandom), 16'($urandom),
                          8'($urandom)});
  endtask

  // stop offering and wait until every query has been answered
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // writes produce nothing that wait_drained can see, so let the last one land first
  task automatic set_palette_size(input logic [SizeW-1:0] value);
    wait_drained();
    repeat (8) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  function automatic logic [7:0] nudge(input logic [7:0] v);
    int t;
    t = int'(v) + int'($urandom_range(6)) - 3;
    if (t < 0) t = 0;
    if (t > 255) t = 255;
    return t[7:0];
  endfunction

  // new entry anywhere; a quarter reuse an existing color so ties appear
  task automatic random_write();
    logic [EntryW-1:0] twin;
    if ($urandom_range(3) == 0) begin
      twin = shade[$urandom_range(PaletteDepth - 1)];
      send_write(8'($urandom), {twin[23:16], 8'($urandom)}, {twin[15:8], 8'($urandom)},
                 {twin[7:0], 8'($urandom)});
    end else begin
      send_write(8'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    end
  endtask

  // aim at a searched entry (exact), next to one, or anywhere
  task automatic random_query(input int unsigned span);
    logic [EntryW-1:0] pick;
    int unsigned roll;
    roll = $urandom_range(99);
    if (span == 0 || roll < 30) begin
      pick = EntryW'($urandom);
    end else begin
      pick = shade[$urandom_range(span - 1)];
      if (roll < 60) pick = {nudge(pick[23:16]), nudge(pick[15:8]), nudge(pick[7:0])};
    end
    send_query(pick[23:16], pick[15:8], pick[7:0]);
  endtask

  initial begin : stimulus
    int unsigned phase_size [8] = '{256, 17, 511, 1, 0, 2, 0, 256};
    int unsigned p, n, i, span;
    logic [SizeW-1:0] size_now;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty palette answers 0 whatever the target
    set_palette_size('0);
    send_query(8'h00, 8'h00, 8'h00);
    send_query(8'hFF, 8'hFF, 8'hFF);

    // channel extremes; low byte of each channel must be dropped;
    // entries 2 and 3 collapse to the same color
    send_write(8'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_write(8'd1, 16'h0000, 16'h0000, 16'h0000);
    send_write(8'd2, 16'h80FF, 16'h7F00, 16'h40AA);
    send_write(8'd3, 16'h8000, 16'h7FFF, 16'h4000);
    send_write(8'd255, 16'h00FF, 16'hFF00, 16'h5A5A);

    // one white entry: black target is too far, nothing qualifies
    set_palette_size(9'd1);
    send_query(8'h00, 8'h00, 8'h00);
    send_query(8'hFF, 8'hFF, 8'hFF);
    send_query(8'h80, 8'h80, 8'h80);

    // exact hits still scan every entry; the tie between 2 and 3 goes to 2
    set_palette_size(9'd4);
    send_query(8'h00, 8'h00, 8'h00);
    send_query(8'h80, 8'h7F, 8'h40);
    send_query(8'h81, 8'h7F, 8'h40);
    send_query(8'hFF, 8'h00, 8'h00);
    send_query(8'h00, 8'hFF, 8'hFF);
    send_query(8'h40, 8'h40, 8'h40);

    // fill the whole palette so any size may be searched from here on
    set_palette_size(9'd256);
    for (i = 0; i < PaletteDepth; i++) begin
      if (i > 0 && $urandom_range(4) == 0)
        send_write(8'(i), {shade[i - 1][23:16], 8'($urandom)},
                   {shade[i - 1][15:8], 8'($urandom)}, {shade[i - 1][7:0], 8'($urandom)});
      else
        send_write(8'(i), 16'($urandom), 16'($urandom), 16'($urandom));
    end

    // random phases: phase 1 holds the receiver off long enough to stall the
    // input, phase 2 pauses the sender until drained, phase 3 never idles
    for (p = 0; p < 8; p++) begin
      size_now = (p == 6) ? SizeW'($urandom_range(511)) : SizeW'(phase_size[p]);
      set_palette_size(size_now);
      span = (size_now > PaletteDepth) ? PaletteDepth : size_now;
      tx_calm <= (p == 3);
      rx_calm <= (p == 3);
      if (p == 1) rx_hold_go <= 1'b1;
      for (n = 0; n < PhaseItems; n++) begin
        if (p == 2 && n == PhaseItems / 2) wait_drained();
        if ($urandom_range(99) < 35) random_write();
        else random_query(span);
      end
    end

    wait_drained();
    repeat (16) @(posedge clk_i);

    $display("run covered %0d palette writes and %0d queries, %0d results compared",
             writes_sent, queries_sent, checked);
    $display("palette sizes 0, 1, 2, 4, 17, 256, 511 and random; empty, out-of-range, exact-hit"
             , " and tie cases; long output stall and drained pause");
    if (fail_count == 0 && pending == 0) begin
      $display("tb_nearest_palette_color_search_top OK");
    end else begin
      $display("tb_nearest_palette_color_search_top NOT OK");
    end
    $finish;
  end

endmodule
